// ===== sv/tpcu_pkg.sv =====
`default_nettype none

package tpcu_pkg;

    // Number of fields in one pattern cell.
    localparam int unsigned FIELD_COUNT = 5;

    // Result status codes.
    localparam logic [1:0] STATUS_CELL      = 2'd0;
    localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
    localparam logic [1:0] STATUS_TRUNCATED = 2'd2;

    // Register indexes on the configuration port.
    localparam logic REG_CHANNEL_COUNT = 1'b0;
    localparam logic REG_ROW_COUNT     = 1'b1;

    // Mask loaded by a lead byte with bit 7 clear: the note is already in,
    // the four other fields follow.
    localparam logic [4:0] FULL_CELL_REST = 5'b11110;

    typedef logic [7:0] field_t;

    typedef struct packed {
        logic [4:0] channel_index;
        logic [7:0] row_index;
        field_t     note_value;
        field_t     instrument_number;
        field_t     volume_value;
        field_t     effect_code;
        field_t     effect_argument;
        logic [1:0] status_code;
        logic       pattern_end;
    } result_t;

endpackage

`default_nettype wire

// ===== sv/tracker_pattern_cell_unpacker.sv =====
`default_nettype none

// Channel   Handshake                  Payload
// -------   ------------------------   -------------------------------------------
// byte      byte_valid / byte_stall    data_byte, last_byte
// cell      cell_valid / cell_stall    channel_index, row_index, note_value,
//                                      instrument_number, volume_value,
//                                      effect_code, effect_argument,
//                                      status_code, pattern_end
// config    APB (psel/penable/pwrite)  paddr, pwdata, prdata, pready
//
// One byte is taken per cycle while byte_stall is low; its result, if it makes one, is
// registered in the output register, or in the skid register while that one holds a stalled beat.
// The unpacking state and the decode of the current byte form one register stage;
// the output register and a one-beat skid register set the throughput.
// byte_stall rises only when both the output register and the skid register hold
// beats, so one stalled result does not hold up the byte stream.
// Reset (rst_n low, asynchronous) empties both output registers, clears the
// cell state and position, and loads channel_count = 8 and row_count = 64.
module tracker_pattern_cell_unpacker #(
    parameter int unsigned MAX_CHANNELS = 32,
    parameter int unsigned MAX_ROWS     = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,

    input  wire logic        byte_valid,
    output logic             byte_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        last_byte,

    output logic             cell_valid,
    input  wire logic        cell_stall,
    output logic      [4:0]  channel_index,
    output logic      [7:0]  row_index,
    output logic      [7:0]  note_value,
    output logic      [7:0]  instrument_number,
    output logic      [7:0]  volume_value,
    output logic      [7:0]  effect_code,
    output logic      [7:0]  effect_argument,
    output logic      [1:0]  status_code,
    output logic             pattern_end
);

    // Effective caps on the position counters. The channel counter is five bits
    // wide, so the channel cap never exceeds 32.
    localparam logic [5:0] CH_CAP  = 6'((MAX_CHANNELS < 32) ? MAX_CHANNELS : 32);
    localparam logic [8:0] ROW_CAP = 9'((MAX_ROWS < 256) ? MAX_ROWS : 256);

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [5:0] channel_count_reg;
    logic [8:0] row_count_reg;
    logic       cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_count_reg <= 6'd8;
            row_count_reg     <= 9'd64;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == tpcu_pkg::REG_CHANNEL_COUNT)
            begin
                channel_count_reg <= pwdata[5:0];
            end
            else
            begin
                row_count_reg <= pwdata[8:0];
            end
        end
    end

    always_comb
    begin
        if (paddr[2] == tpcu_pkg::REG_CHANNEL_COUNT)
        begin
            prdata = {26'd0, channel_count_reg};
        end
        else
        begin
            prdata = {23'd0, row_count_reg};
        end
    end

    // A zero count acts as one; counts above the caps saturate.
    logic [5:0] ch_limit;
    logic [8:0] row_limit;

    always_comb
    begin
        ch_limit = (channel_count_reg == 6'd0) ? 6'd1 : channel_count_reg;
        if (ch_limit > CH_CAP)
        begin
            ch_limit = CH_CAP;
        end
        row_limit = (row_count_reg == 9'd0) ? 9'd1 : row_count_reg;
        if (row_limit > ROW_CAP)
        begin
            row_limit = ROW_CAP;
        end
    end

    // ------------------------------------------------------------------
    // Cell assembly state.
    // ------------------------------------------------------------------
    logic [4:0]             pending_reg, pending_next;
    tpcu_pkg::field_t [4:0] cell_reg, cell_next;
    logic [4:0]             chan_reg, chan_next;
    logic [8:0]             row_reg, row_next;

    logic              byte_fire;
    logic              res_valid;
    tpcu_pkg::result_t res;
    logic [4:0]        first_pending;
    logic [5:0]        chan_plus;

    always_comb
    begin
        cell_next     = cell_reg;
        pending_next  = pending_reg;
        chan_next     = chan_reg;
        row_next      = row_reg;
        res_valid     = 1'b0;
        res           = '0;
        first_pending = pending_reg & (~pending_reg + 5'd1);
        chan_plus     = {1'b0, chan_reg} + 6'd1;

        if (pending_reg == 5'd0)
        begin
            // Lead byte: a new cell starts with all fields cleared.
            cell_next = '0;
            if (data_byte[7])
            begin
                pending_next = data_byte[4:0];
            end
            else
            begin
                cell_next[0] = data_byte;
                pending_next = tpcu_pkg::FULL_CELL_REST;
            end
        end
        else
        begin
            // Field byte: it fills the lowest field still expected.
            for (int i = 0; i < tpcu_pkg::FIELD_COUNT; i++)
            begin
                if (first_pending[i])
                begin
                    cell_next[i] = data_byte;
                end
            end
            pending_next = pending_reg & ~first_pending;
        end

        if (pending_next == 5'd0)
        begin
            res_valid       = 1'b1;
            res.pattern_end = last_byte;
            if (row_reg >= row_limit)
            begin
                // The pattern has no row left for this cell; it is dropped.
                res.status_code = tpcu_pkg::STATUS_OVERFLOW;
            end
            else
            begin
                res.status_code       = tpcu_pkg::STATUS_CELL;
                res.channel_index     = chan_reg;
                res.row_index         = row_reg[7:0];
                res.note_value        = cell_next[0];
                res.instrument_number = cell_next[1];
                res.volume_value      = cell_next[2];
                res.effect_code       = cell_next[3];
                res.effect_argument   = cell_next[4];
                // A channel at or past the limit also wraps, which covers a
                // limit lowered in the middle of a pattern.
                if (chan_plus >= ch_limit)
                begin
                    chan_next = 5'd0;
                    row_next  = row_reg + 9'd1;
                end
                else
                begin
                    chan_next = chan_plus[4:0];
                end
            end
        end
        else if (last_byte)
        begin
            res_valid       = 1'b1;
            res.status_code = tpcu_pkg::STATUS_TRUNCATED;
            res.pattern_end = 1'b1;
        end

        // The last byte of a pattern returns everything to the start.
        if (last_byte)
        begin
            pending_next = 5'd0;
            cell_next    = '0;
            chan_next    = 5'd0;
            row_next     = 9'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 5'd0;
            cell_reg    <= '0;
            chan_reg    <= 5'd0;
            row_reg     <= 9'd0;
        end
        else if (byte_fire)
        begin
            pending_reg <= pending_next;
            cell_reg    <= cell_next;
            chan_reg    <= chan_next;
            row_reg     <= row_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register with a one-beat skid register behind it. The skid
    // register fills only when a result arrives while the output register
    // holds a stalled beat.
    // ------------------------------------------------------------------
    logic              out_valid_reg;
    tpcu_pkg::result_t out_reg;
    logic              skid_valid_reg;
    tpcu_pkg::result_t skid_reg;
    logic              out_free;
    logic              new_valid;

    assign byte_stall = skid_valid_reg;
    assign byte_fire  = byte_valid & ~skid_valid_reg;
    assign out_free   = ~out_valid_reg | ~cell_stall;
    assign new_valid  = byte_fire & res_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= new_valid;
            end
            else
            begin
                out_valid_reg <= new_valid;
            end
        end
        else if (new_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
                if (new_valid)
                begin
                    skid_reg <= res;
                end
            end
            else if (new_valid)
            begin
                out_reg <= res;
            end
        end
        else if (new_valid)
        begin
            skid_reg <= res;
        end
    end

    assign cell_valid        = out_valid_reg;
    assign channel_index     = out_reg.channel_index;
    assign row_index         = out_reg.row_index;
    assign note_value        = out_reg.note_value;
    assign instrument_number = out_reg.instrument_number;
    assign volume_value      = out_reg.volume_value;
    assign effect_code       = out_reg.effect_code;
    assign effect_argument   = out_reg.effect_argument;
    assign status_code       = out_reg.status_code;
    assign pattern_end       = out_reg.pattern_end;

endmodule

`default_nettype wire
